// ===== sv/pftf_pkg.sv =====
// Shared types, codes and constants of the perspective floor texel fetch block.
`timescale 1ns / 1ps
`default_nettype none

package pftf_pkg;

  // Default values of the top-level parameters.
  localparam int TILE_ADDR_BITS_DEF = 16;
  localparam int MAX_ROWS_DEF       = 256;

  // Field and datapath widths.
  localparam int SCALE_W  = 10;
  localparam int LOG2_W   = 4;
  localparam int DIST_W   = 3 * SCALE_W;
  localparam int CNT_W    = $clog2(DIST_W);
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  // Register word indexes on the configuration port.
  localparam logic [2:0] REG_CAM_HEIGHT  = 3'd0;
  localparam logic [2:0] REG_VSCALE      = 3'd1;
  localparam logic [2:0] REG_HSCALE      = 3'd2;
  localparam logic [2:0] REG_LINE_WIDTH  = 3'd3;
  localparam logic [2:0] REG_TILE_W_LOG2 = 3'd4;
  localparam logic [2:0] REG_TILE_H_LOG2 = 3'd5;

  // Register reset values.
  localparam logic [SCALE_W-1:0] CAM_HEIGHT_RST  = 10'd64;
  localparam logic [SCALE_W-1:0] VSCALE_RST      = 10'd1;
  localparam logic [SCALE_W-1:0] HSCALE_RST      = 10'd1;
  localparam logic [SCALE_W-1:0] LINE_WIDTH_RST  = 10'd320;
  localparam logic [LOG2_W-1:0]  TILE_W_LOG2_RST = 4'd8;
  localparam logic [LOG2_W-1:0]  TILE_H_LOG2_RST = 4'd8;

  typedef enum logic [1:0] {
    MODE_TEXEL = 2'd0,
    MODE_ROW   = 2'd1,
    MODE_PIXEL = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DIV_IDLE  = 2'd0,
    DIV_DIST  = 2'd1,
    DIV_STEP  = 2'd2,
    DIV_WRITE = 2'd3
  } div_state_e;

endpackage

`default_nettype wire

// ===== sv/pftf_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pftf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/perspective_floor_texel_fetch.sv =====
// Top level of the perspective floor texel fetch block: row tables, divider and pixel pipeline.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  mode, tile_addr, texel_in, row, column,
//                                                cam_x, cam_y
//   out      output     out_valid_o / out_stall_i pixel
//   config   input      APB psel/penable/pwrite  six registers at byte address 4*i
//
// Texel and pixel items are taken one per cycle when not stalled; a pixel goes through stage 1,
// stage 2 and the output register. An in-range row item holds the input while the shared
// restoring divider makes one quotient bit per cycle for the distance, then for the step, then
// writes the table. Reset clears the configuration registers and control state, not the tile
// store or row tables. A stalled output freezes the whole pixel pipeline and the input with it.
`timescale 1ns / 1ps
`default_nettype none

module perspective_floor_texel_fetch
  import pftf_pkg::*;
#(
  parameter int TILE_ADDR_BITS = TILE_ADDR_BITS_DEF,
  parameter int MAX_ROWS       = MAX_ROWS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready,

  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [15:0]         tile_addr_i,
  input  wire logic [15:0]         texel_in_i,
  input  wire logic [7:0]          row_i,
  input  wire logic [8:0]          column_i,
  input  wire logic signed [15:0]  cam_x_i,
  input  wire logic signed [20:0]  cam_y_i,

  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [15:0]         pixel_o
);

  localparam int RowAw = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int TabW  = TILE_ADDR_BITS;
  localparam logic [CNT_W-1:0] CntLast = CNT_W'(DIST_W - 1);

  // Configuration registers.
  logic [SCALE_W-1:0] cam_height_q, vscale_q, hscale_q, line_width_q;
  logic [LOG2_W-1:0]  tw_log2_q, th_log2_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_height_q <= CAM_HEIGHT_RST;
      vscale_q     <= VSCALE_RST;
      hscale_q     <= HSCALE_RST;
      line_width_q <= LINE_WIDTH_RST;
      tw_log2_q    <= TILE_W_LOG2_RST;
      th_log2_q    <= TILE_H_LOG2_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_CAM_HEIGHT:  cam_height_q <= pwdata[SCALE_W-1:0];
        REG_VSCALE:      vscale_q     <= pwdata[SCALE_W-1:0];
        REG_HSCALE:      hscale_q     <= pwdata[SCALE_W-1:0];
        REG_LINE_WIDTH:  line_width_q <= pwdata[SCALE_W-1:0];
        REG_TILE_W_LOG2: tw_log2_q    <= pwdata[LOG2_W-1:0];
        REG_TILE_H_LOG2: th_log2_q    <= pwdata[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CAM_HEIGHT:  prdata = PDATA_W'(cam_height_q);
      REG_VSCALE:      prdata = PDATA_W'(vscale_q);
      REG_HSCALE:      prdata = PDATA_W'(hscale_q);
      REG_LINE_WIDTH:  prdata = PDATA_W'(line_width_q);
      REG_TILE_W_LOG2: prdata = PDATA_W'(tw_log2_q);
      REG_TILE_H_LOG2: prdata = PDATA_W'(th_log2_q);
      default:         prdata = '0;
    endcase
  end

  // Input decode.
  logic             adv, busy, in_accept;
  logic             is_tex, is_row, is_pix, row_ok;
  logic [31:0]      row_ext;
  logic [RowAw-1:0] row_idx;
  logic [TabW-1:0]  in_taddr;
  logic [31:0]      taddr_ext;
  logic             out_valid_q, out_rok_q;

  always_comb begin
    is_tex = 1'b0;
    is_row = 1'b0;
    is_pix = 1'b0;
    case (mode_e'(mode_i))
      MODE_TEXEL: is_tex = 1'b1;
      MODE_ROW:   is_row = 1'b1;
      MODE_PIXEL: is_pix = 1'b1;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = busy || !adv;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign row_ext     = 32'(row_i);
  assign row_ok      = row_ext < 32'(MAX_ROWS);
  assign row_idx     = row_ext[RowAw-1:0];
  assign taddr_ext   = 32'(tile_addr_i);
  assign in_taddr    = taddr_ext[TabW-1:0];

  // Row preparation: one restoring divider shared by distance and step.
  div_state_e          div_state_q, div_state_d;
  logic [CNT_W-1:0]    cnt_q;
  logic [SCALE_W-1:0]  rem_q, divisor_q, rem_nxt;
  logic [DIST_W-1:0]   quo_q, dist_q, quo_nxt, num;
  logic [RowAw-1:0]    wr_row_q;
  logic [SCALE_W:0]    shifted, trial;
  logic                take, cnt_last, div_start, stepping, row_we;
  logic [2*SCALE_W-1:0] num_prod;

  assign div_start = in_accept && is_row && row_ok;
  assign cnt_last  = cnt_q == CntLast;
  assign num_prod  = cam_height_q * vscale_q;
  assign num       = {num_prod, {SCALE_W{1'b0}}};
  assign shifted   = {rem_q, quo_q[DIST_W-1]};
  assign take      = shifted >= {1'b0, divisor_q};
  assign trial     = shifted - {1'b0, divisor_q};
  assign rem_nxt   = take ? trial[SCALE_W-1:0] : shifted[SCALE_W-1:0];
  assign quo_nxt   = {quo_q[DIST_W-2:0], take};

  always_comb begin
    div_state_d = div_state_q;
    case (div_state_q)
      DIV_IDLE:  if (div_start) div_state_d = DIV_DIST;
      DIV_DIST:  if (cnt_last) div_state_d = DIV_STEP;
      DIV_STEP:  if (cnt_last) div_state_d = DIV_WRITE;
      DIV_WRITE: div_state_d = DIV_IDLE;
      default:   div_state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    stepping = 1'b0;
    row_we   = 1'b0;
    case (div_state_q)
      DIV_IDLE:  busy = 1'b0;
      DIV_DIST:  stepping = 1'b1;
      DIV_STEP:  stepping = 1'b1;
      DIV_WRITE: row_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_IDLE;
      cnt_q       <= '0;
    end else begin
      div_state_q <= div_state_d;
      if (div_start || (stepping && cnt_last)) begin
        cnt_q <= '0;
      end else if (stepping) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      quo_q     <= num;
      rem_q     <= '0;
      divisor_q <= (row_i == 8'd0) ? SCALE_W'(1) : SCALE_W'(row_i);
      wr_row_q  <= row_idx;
    end else if (div_state_q == DIV_DIST && cnt_last) begin
      dist_q    <= quo_nxt;
      quo_q     <= quo_nxt;
      rem_q     <= '0;
      divisor_q <= hscale_q;
    end else if (stepping) begin
      quo_q <= quo_nxt;
      rem_q <= rem_nxt;
    end
  end

  // Row tables: distance in the upper half, step in the lower half.
  logic                  row_rd, row_en;
  logic [RowAw-1:0]      row_addr;
  logic [2*DIST_W-1:0]   row_wdata, row_rdata;
  logic [DIST_W-1:0]     step_wr, rd_dist, rd_step;

  assign row_rd    = in_accept && is_pix && row_ok;
  assign row_en    = row_we || row_rd;
  assign row_addr  = row_we ? wr_row_q : row_idx;
  assign step_wr   = (hscale_q == '0) ? '0 : quo_q;
  assign row_wdata = {dist_q, step_wr};
  assign rd_dist   = row_rdata[2*DIST_W-1:DIST_W];
  assign rd_step   = row_rdata[DIST_W-1:0];

  pftf_ram #(
    .WIDTH (2 * DIST_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .en_i    (row_en),
    .we_i    (row_we),
    .addr_i  (row_addr),
    .wdata_i (row_wdata),
    .rdata_o (row_rdata)
  );

  // Pixel pipeline: stage 1 multiplies, stage 2 forms the tile address, stage 3 is the output.
  logic               s1_tex_q, s1_pix_q, s1_rok_q;
  logic [8:0]         s1_col_q;
  logic [15:0]        s1_camx_q;
  logic [20:0]        s1_camy_q;
  logic [TabW-1:0]    s1_taddr_q;
  logic [15:0]        s1_texel_q;

  logic               s2_tex_q, s2_pix_q, s2_rok_q;
  logic [31:0]        s2_prod_q;
  logic [14:0]        s2_tx_q;
  logic [20:0]        s2_camy_q;
  logic [TabW-1:0]    s2_taddr_q;
  logic [15:0]        s2_texel_q;

  logic signed [10:0] ofs;
  logic signed [41:0] prod_full;
  logic [15:0]        tx_sum;
  logic [14:0]        wmask, hmask, tx, ty;
  logic [15:0]        wmask_full, hmask_full;
  logic [31:0]        camy_sh, v, addr_full;
  logic [TabW-1:0]    pix_addr, tile_addr;
  logic               tile_en;
  logic [15:0]        tile_rdata;

  assign ofs        = $signed({2'b00, s1_col_q}) - $signed({2'b00, line_width_q[SCALE_W-1:1]});
  assign prod_full  = ofs * $signed({1'b0, rd_step});
  assign wmask_full = (16'd1 << tw_log2_q) - 16'd1;
  assign hmask_full = (16'd1 << th_log2_q) - 16'd1;
  assign wmask      = wmask_full[14:0];
  assign hmask      = hmask_full[14:0];
  assign tx_sum     = s1_camx_q + rd_dist[25:10];
  assign tx         = tx_sum[14:0] & wmask;

  assign camy_sh    = {s2_camy_q[20], s2_camy_q, 10'b0};
  assign v          = camy_sh + s2_prod_q;
  assign ty         = v[24:10] & hmask;
  assign addr_full  = (32'(ty) << tw_log2_q) + 32'(s2_tx_q);
  assign pix_addr   = addr_full[TabW-1:0];
  assign tile_en    = adv && (s2_tex_q || (s2_pix_q && s2_rok_q));
  assign tile_addr  = s2_tex_q ? s2_taddr_q : pix_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tex_q    <= 1'b0;
      s1_pix_q    <= 1'b0;
      s1_rok_q    <= 1'b0;
      s2_tex_q    <= 1'b0;
      s2_pix_q    <= 1'b0;
      s2_rok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_rok_q   <= 1'b0;
    end else if (adv) begin
      s1_tex_q    <= in_accept && is_tex;
      s1_pix_q    <= in_accept && is_pix;
      s1_rok_q    <= row_ok;
      s2_tex_q    <= s1_tex_q;
      s2_pix_q    <= s1_pix_q;
      s2_rok_q    <= s1_rok_q;
      out_valid_q <= s2_pix_q;
      out_rok_q   <= s2_rok_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q   <= column_i;
      s1_camx_q  <= cam_x_i;
      s1_camy_q  <= cam_y_i;
      s1_taddr_q <= in_taddr;
      s1_texel_q <= texel_in_i;
      s2_prod_q  <= prod_full[31:0];
      s2_tx_q    <= tx;
      s2_camy_q  <= s1_camy_q;
      s2_taddr_q <= s1_taddr_q;
      s2_texel_q <= s1_texel_q;
    end
  end

  pftf_ram #(
    .WIDTH (16),
    .DEPTH (2 ** TabW)
  ) u_tile_ram (
    .clk_i   (clk_i),
    .en_i    (tile_en),
    .we_i    (s2_tex_q),
    .addr_i  (tile_addr),
    .wdata_i (s2_texel_q),
    .rdata_o (tile_rdata)
  );

  assign pixel_o = out_rok_q ? tile_rdata : 16'd0;

`ifndef SYNTHESIS
  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_state_q == DIV_DIST)
    else $error("Row item did not start the divider.");

  a_no_accept_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we |-> !in_accept)
    else $error("Item accepted while the row tables are written.");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_state_q == DIV_DIST || div_state_q == DIV_STEP) |-> cnt_q <= CntLast)
    else $error("Divider count out of range.");

  a_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we && hscale_q == '0 |-> row_wdata[DIST_W-1:0] == '0)
    else $error("Zero horizontal scale did not give a zero step.");

  a_out_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_pix_q))
    else $error("Result appeared without a pixel item.");
`endif

endmodule

`default_nettype wire
